@@ hw/rtl/psq_pkg.sv @@
package psq_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_ROUTE = 2'd1;
  localparam logic [1:0] FUNC_DEL   = 2'd2;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_PURGED   = 3'd1,
    KIND_DELETED  = 3'd2,
    KIND_ADDED    = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_NOTFOUND = 3'd5,
    KIND_DONE     = 3'd6
  } kind_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [15:0] port;
    logic [31:0] bid;
    logic [31:0] stamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic  accept;
    logic  add_entry;
    logic  rd_cur;
    logic  rd_next;
    logic  keep;
    logic  skip;
    logic  remove;
    logic  del_hit;
    logic  shift_wr;
    logic  finish_route;
    logic  emit;
    kind_e kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       scan_more;
    logic       shift_more;
    logic       full;
    logic       live;
    logic       dest_hit;
    logic       port_hit;
    logic       out_free;
  } status_t;

endpackage

@@ hw/rtl/psq_ctrl.sv @@
module psq_ctrl
  import psq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.kind = KIND_DONE;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        case (st_i.func)
          FUNC_ADD: begin
            if (st_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.kind      = st_i.full ? KIND_FULL : KIND_ADDED;
              cmd_o.add_entry = !st_i.full;
              state_d         = S_IDLE;
            end
          end
          FUNC_ROUTE, FUNC_DEL: state_d = S_SCAN;
          default: begin
            if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KIND_DONE;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (st_i.scan_more) begin
          cmd_o.rd_cur = 1'b1;
          state_d      = S_EVAL;
        end else if (st_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.kind         = (st_i.func == FUNC_ROUTE) ? KIND_DONE : KIND_NOTFOUND;
          cmd_o.finish_route = (st_i.func == FUNC_ROUTE);
          state_d            = S_IDLE;
        end
      end
      S_EVAL: begin
        if (st_i.func == FUNC_ROUTE) begin
          if (st_i.live && !st_i.dest_hit) begin
            cmd_o.keep = 1'b1;
            state_d    = S_SCAN;
          end else if (st_i.out_free) begin
            cmd_o.remove = 1'b1;
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = st_i.live ? KIND_SEND : KIND_PURGED;
            state_d      = S_SCAN;
          end
        end else begin
          if (!st_i.port_hit) begin
            cmd_o.skip = 1'b1;
            state_d    = S_SCAN;
          end else if (st_i.out_free) begin
            cmd_o.del_hit = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = KIND_DELETED;
            state_d       = S_SHRD;
          end
        end
      end
      S_SHRD: begin
        if (st_i.shift_more) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHWR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/psq_dp.sv @@
module psq_dp
  import psq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     st_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] broadcast_id_i,
  input  logic [7:0]  msg_handle_i,
  input  logic [7:0]  ifindex_i,
  input  logic [31:0] nexthop_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  msg_handle_res_o,
  output logic [31:0] broadcast_id_res_o,
  output logic [7:0]  ifindex_res_o,
  output logic [31:0] nexthop_res_o,
  output logic [4:0]  count_o,
  output logic        last_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  entry_t                 mem_e [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] mem_h [QUEUE_DEPTH];

  logic [15:0]   timeout_q;
  logic [CW-1:0] count_q, total_q, i_q, w_q;
  logic [1:0]    func_q;
  logic [31:0]   now_q, dest_q, bid_q, nh_q;
  logic [15:0]   port_q;
  logic [7:0]    handle_q, ifx_q;

  entry_t                 rd_e_q;
  logic [HANDLE_BITS-1:0] rd_h_q;

  // handle as stored, then as reported
  logic [15:0]            hin16, hrd16, hnew16;
  logic [HANDLE_BITS-1:0] hin;
  assign hin16  = {8'b0, handle_q};
  assign hin    = hin16[HANDLE_BITS-1:0];
  assign hrd16  = 16'(rd_h_q);
  assign hnew16 = 16'(hin);

  logic [31:0] age;
  assign age = now_q - rd_e_q.stamp;

  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    st_o.func       = func_q;
    st_o.scan_more  = (i_q < total_q);
    st_o.shift_more = ((i_q + ONE_C) < total_q);
    st_o.full       = (count_q >= DEPTH_C);
    st_o.live       = (age < {16'b0, timeout_q});
    st_o.dest_hit   = (rd_e_q.dest == dest_q);
    st_o.port_hit   = (rd_e_q.port == port_q);
    st_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd3;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q   <= func_i;
      now_q    <= now_i;
      dest_q   <= dest_addr_i;
      port_q   <= src_port_i;
      bid_q    <= broadcast_id_i;
      handle_q <= msg_handle_i;
      ifx_q    <= ifindex_i;
      nh_q     <= nexthop_i;
    end
  end

  // count and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      i_q     <= '0;
      w_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        total_q <= count_q;
        i_q     <= '0;
        w_q     <= '0;
      end
      if (cmd_i.add_entry) count_q <= count_q + ONE_C;
      if (cmd_i.keep) begin
        w_q <= w_q + ONE_C;
        i_q <= i_q + ONE_C;
      end
      if (cmd_i.skip || cmd_i.remove || cmd_i.shift_wr) i_q <= i_q + ONE_C;
      if (cmd_i.del_hit) count_q <= count_q - ONE_C;
      if (cmd_i.finish_route) count_q <= w_q;
    end
  end

  // entry store: one write, one registered read
  logic [CW-1:0] wa, ra;
  always_comb begin
    if (cmd_i.add_entry) wa = count_q;
    else if (cmd_i.keep) wa = w_q;
    else                 wa = i_q;
    ra = cmd_i.rd_next ? (i_q + ONE_C) : i_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_entry) begin
      mem_e[wa[IW-1:0]] <= '{dest: dest_q, port: port_q, bid: bid_q, stamp: now_q};
      mem_h[wa[IW-1:0]] <= hin;
    end else if (cmd_i.keep || cmd_i.shift_wr) begin
      mem_e[wa[IW-1:0]] <= rd_e_q;
      mem_h[wa[IW-1:0]] <= rd_h_q;
    end
    if (cmd_i.rd_cur || cmd_i.rd_next) begin
      rd_e_q <= mem_e[ra[IW-1:0]];
      rd_h_q <= mem_h[ra[IW-1:0]];
    end
  end

  // result register
  logic [CW-1:0] cnt_res;
  logic [31:0]   cnt_ext;
  always_comb begin
    case (cmd_i.kind)
      KIND_ADDED:              cnt_res = count_q + ONE_C;
      KIND_DELETED:            cnt_res = count_q - ONE_C;
      KIND_SEND, KIND_PURGED:  cnt_res = w_q + total_q - i_q - ONE_C;
      KIND_DONE:               cnt_res = (func_q == FUNC_ROUTE) ? w_q : count_q;
      default:                 cnt_res = count_q;
    endcase
  end
  assign cnt_ext = 32'(cnt_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o             <= cmd_i.kind;
      count_o            <= cnt_ext[4:0];
      last_o             <= !(cmd_i.kind == KIND_SEND || cmd_i.kind == KIND_PURGED);
      ifindex_res_o      <= (cmd_i.kind == KIND_SEND) ? ifx_q : 8'd0;
      nexthop_res_o      <= (cmd_i.kind == KIND_SEND) ? nh_q : 32'd0;
      case (cmd_i.kind)
        KIND_SEND, KIND_PURGED, KIND_DELETED: begin
          msg_handle_res_o   <= hrd16[7:0];
          broadcast_id_res_o <= rd_e_q.bid;
        end
        KIND_ADDED: begin
          msg_handle_res_o   <= hnew16[7:0];
          broadcast_id_res_o <= bid_q;
        end
        default: begin
          msg_handle_res_o   <= 8'd0;
          broadcast_id_res_o <= 32'd0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pending_send_queue.sv @@
// Ordered buffer of payloads waiting for a route.
// Input channel (in_valid_i / in_stall_o) takes one request per beat:
//   add, route found, or delete by source port. Output channel
//   (out_valid_o / out_stall_i) returns result beats; last_o marks the
//   final beat of a request.
// Add and delete give one result; route found gives one beat per
// removed entry (send or purged) plus a final done beat.
// Steps: add is taken, then dispatched, which loads its result. Route found
//   walks the entry store through its single read port: a read and an
//   evaluate step per entry, plus take, dispatch and done. Delete scans the
//   same way up to the hit, then shifts the tail up with a read and a write
//   step per entry. Requests are served one at a time; in_stall_o is high while busy.
// The result register frees the input side: a new request is taken
//   while the last result beat still waits. When the receiver stalls,
//   the walk holds at the next entry that must emit.
// Reset: buffer empty, timeout register back to 3 s. No clearing pass.
// cfg_we_i writes timeout_seconds; write only while idle.
module pending_send_queue
  import psq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] broadcast_id_i,
  input  logic [7:0]  msg_handle_i,
  input  logic [7:0]  ifindex_i,
  input  logic [31:0] nexthop_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  msg_handle_res_o,
  output logic [31:0] broadcast_id_res_o,
  output logic [7:0]  ifindex_res_o,
  output logic [31:0] nexthop_res_o,
  output logic [4:0]  count_o,
  output logic        last_o
);

  cmd_t    cmd;
  status_t st;

  psq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  psq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .now_i              (now_i),
    .dest_addr_i        (dest_addr_i),
    .src_port_i         (src_port_i),
    .broadcast_id_i     (broadcast_id_i),
    .msg_handle_i       (msg_handle_i),
    .ifindex_i          (ifindex_i),
    .nexthop_i          (nexthop_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .msg_handle_res_o   (msg_handle_res_o),
    .broadcast_id_res_o (broadcast_id_res_o),
    .ifindex_res_o      (ifindex_res_o),
    .nexthop_res_o      (nexthop_res_o),
    .count_o            (count_o),
    .last_o             (last_o)
  );

  // an accepted request always keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but block not busy");

  // per-entry beats of a route walk are never the final beat
  a_send_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_SEND || kind_o == KIND_PURGED) |-> !last_o)
    else $error("send/purged beat flagged last");

  // the controller only emits when the result register can take it
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> st.out_free)
    else $error("result emitted over a waiting beat");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for pending_send_queue.
// Requests go in through a valid/stall channel, result beats come back on a
// second valid/stall channel. A behavioral copy of the buffer, kept here,
// predicts every result beat for each request beat taken by the block.
module tb_top;
  import psq_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused code, answers "done"
  localparam int DEPTH = 16;
  localparam int DRAIN_CYCLES = 80;         // longer than a full-depth route walk, with margin
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] now;
    logic [31:0] dest;
    logic [15:0] port;
    logic [31:0] bid;
    logic [7:0]  handle;
    logic [7:0]  ifx;
    logic [31:0] nh;
  } request_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  handle;
    logic [31:0] bid;
    logic [7:0]  ifx;
    logic [31:0] nh;
    logic [4:0]  count;
    logic        last;
  } result_t;

  typedef struct {
    logic [31:0] dest;
    logic [15:0] port;
    logic [31:0] bid;
    logic [31:0] stamp;
    logic [7:0]  handle;
  } slot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [31:0] now_i = '0;
  logic [31:0] dest_addr_i = '0;
  logic [15:0] src_port_i = '0;
  logic [31:0] broadcast_id_i = '0;
  logic [7:0]  msg_handle_i = '0;
  logic [7:0]  ifindex_i = '0;
  logic [31:0] nexthop_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  msg_handle_res_o;
  logic [31:0] broadcast_id_res_o;
  logic [7:0]  ifindex_res_o;
  logic [31:0] nexthop_res_o;
  logic [4:0]  count_o;
  logic        last_o;

  pending_send_queue dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .func_i, .now_i, .dest_addr_i, .src_port_i, .broadcast_id_i,
    .msg_handle_i, .ifindex_i, .nexthop_i,
    .out_valid_o, .out_stall_i,
    .kind_o, .msg_handle_res_o, .broadcast_id_res_o, .ifindex_res_o,
    .nexthop_res_o, .count_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  slot_t       held[$];
  logic [15:0] timeout_s = 16'd3;
  result_t     expected_beats[$];
  request_t    pending_reqs[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int reqs_taken = 0;
  int beats_seen = 0;
  int sends_seen = 0;
  int purges_seen = 0;
  int fulls_seen = 0;
  int quiet_cycles = 0;

  function automatic void push_beat(kind_e k, logic [7:0] h, logic [31:0] b,
                                    logic [7:0] ifx, logic [31:0] nh,
                                    int cnt, logic lst);
    result_t r;
    r.kind = k; r.handle = h; r.bid = b; r.ifx = ifx; r.nh = nh;
    r.count = cnt[4:0]; r.last = lst;
    expected_beats.push_back(r);
  endfunction

  // Applies one request to the buffer copy and queues the beats it causes.
  function automatic void apply_request(request_t q);
    slot_t s;
    slot_t kept[$];
    int total;
    logic live;
    logic [31:0] age;
    case (q.func)
      FUNC_ADD: begin
        if (held.size() >= DEPTH) begin
          push_beat(KIND_FULL, '0, '0, '0, '0, held.size(), 1'b1);
        end else begin
          s.dest = q.dest; s.port = q.port; s.bid = q.bid;
          s.stamp = q.now; s.handle = q.handle;
          held.push_back(s);
          push_beat(KIND_ADDED, q.handle, q.bid, '0, '0, held.size(), 1'b1);
        end
      end
      FUNC_ROUTE: begin
        // oldest first: stale entries purged, live matches sent, rest kept
        total = held.size();
        for (int i = 0; i < total; i++) begin
          age = q.now - held[i].stamp;
          live = age < {16'd0, timeout_s};
          if (live && held[i].dest != q.dest) begin
            kept.push_back(held[i]);
          end else if (live) begin
            push_beat(KIND_SEND, held[i].handle, held[i].bid, q.ifx, q.nh,
                      kept.size() + total - i - 1, 1'b0);
          end else begin
            push_beat(KIND_PURGED, held[i].handle, held[i].bid, '0, '0,
                      kept.size() + total - i - 1, 1'b0);
          end
        end
        held = kept;
        push_beat(KIND_DONE, '0, '0, '0, '0, held.size(), 1'b1);
      end
      FUNC_DEL: begin
        for (int i = 0; i < held.size(); i++) begin
          if (held[i].port == q.port) begin
            s = held[i];
            held.delete(i);
            push_beat(KIND_DELETED, s.handle, s.bid, '0, '0, held.size(), 1'b1);
            return;
          end
        end
        push_beat(KIND_NOTFOUND, '0, '0, '0, '0, held.size(), 1'b1);
      end
      default: push_beat(KIND_DONE, '0, '0, '0, '0, held.size(), 1'b1);
    endcase
  endfunction

  // Request driver: payload holds while stalled; next beat picked after a take.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t q;
    logic free_slot;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      free_slot = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        q.func = func_i; q.now = now_i; q.dest = dest_addr_i;
        q.port = src_port_i; q.bid = broadcast_id_i; q.handle = msg_handle_i;
        q.ifx = ifindex_i; q.nh = nexthop_i;
        apply_request(q);
        reqs_taken++;
        free_slot = 1'b1;
      end
      if (free_slot) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          q = pending_reqs.pop_front();
          func_i <= q.func; now_i <= q.now; dest_addr_i <= q.dest;
          src_port_i <= q.port; broadcast_id_i <= q.bid;
          msg_handle_i <= q.handle; ifindex_i <= q.ifx; nexthop_i <= q.nh;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        if (kind_o == KIND_SEND) sends_seen++;
        if (kind_o == KIND_PURGED) purges_seen++;
        if (kind_o == KIND_FULL) fulls_seen++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat kind=%0d handle=%0h count=%0d",
                     kind_o, msg_handle_res_o, count_o);
        end else begin
          e = expected_beats.pop_front();
          if (kind_o !== e.kind || msg_handle_res_o !== e.handle ||
              broadcast_id_res_o !== e.bid || ifindex_res_o !== e.ifx ||
              nexthop_res_o !== e.nh || count_o !== e.count || last_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: beat %0d mismatch", beats_seen);
              $display("  expected kind=%0d h=%0h bid=%0h if=%0h nh=%0h cnt=%0d last=%0b",
                       e.kind, e.handle, e.bid, e.ifx, e.nh, e.count, e.last);
              $display("  actual   kind=%0d h=%0h bid=%0h if=%0h nh=%0h cnt=%0d last=%0b",
                       kind_o, msg_handle_res_o, broadcast_id_res_o, ifindex_res_o,
                       nexthop_res_o, count_o, last_o);
            end
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        pending_reqs.size() == 0 && expected_beats.size() == 0 && !in_valid_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no progress for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus helpers
  logic [31:0] dest_pool[4];
  logic [15:0] port_pool[4];
  logic [31:0] clock_s;

  function automatic request_t make_req(logic [1:0] f, logic [31:0] t,
                                        logic [31:0] d, logic [15:0] p);
    request_t q;
    q.func = f; q.now = t; q.dest = d; q.port = p;
    q.bid = $urandom; q.handle = 8'($urandom_range(255));
    q.ifx = 8'($urandom_range(255)); q.nh = $urandom;
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_s = v;
  endtask

  // Mostly well-formed traffic: adds toward a few destinations, then route
  // replies that hit them, with deletes and noise mixed in.
  task automatic random_phase(int n);
    request_t q;
    int pick;
    @(negedge clk_i);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) clock_s = clock_s + $urandom_range(4, 70000);
      else clock_s = clock_s + $urandom_range(0, 2);
      if (pick < 55) begin
        q = make_req(FUNC_ADD, clock_s, dest_pool[$urandom_range(3)],
                     ($urandom_range(3) == 0) ? 16'($urandom) : port_pool[$urandom_range(3)]);
        if ($urandom_range(9) == 0) q.dest = $urandom;
      end else if (pick < 75) begin
        q = make_req(FUNC_ROUTE, clock_s, dest_pool[$urandom_range(3)], 16'($urandom));
        if ($urandom_range(7) == 0) q.dest = $urandom;
      end else if (pick < 95) begin
        q = make_req(FUNC_DEL, clock_s, $urandom,
                     ($urandom_range(4) == 0) ? 16'($urandom) : port_pool[$urandom_range(3)]);
      end else begin
        q = make_req(FUNC_NONE, $urandom, $urandom, 16'($urandom));
      end
      pending_reqs.push_back(q);
    end
    wait_idle();
  endtask

  initial begin
    request_t q;
    for (int i = 0; i < 4; i++) begin
      dest_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    dest_pool[3] = '1;
    port_pool[3] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset timeout of 3 s, sender 31% idle, receiver 48%
    send_idle_pct = 31;
    recv_idle_pct = 48;
    clock_s = 32'hFFFF_FFFE;  // route check below crosses the 32-bit wrap
    @(negedge clk_i);
    pending_reqs.push_back(make_req(FUNC_ROUTE, clock_s, dest_pool[0], 16'd0));
    pending_reqs.push_back(make_req(FUNC_DEL, clock_s, '0, port_pool[0]));
    pending_reqs.push_back(make_req(FUNC_NONE, clock_s, '0, '0));
    for (int i = 0; i < DEPTH; i++) begin
      q = make_req(FUNC_ADD, clock_s + (i >= 8), dest_pool[i % 3], 16'(i));
      if (i == 0) begin
        q.dest = '0; q.bid = '0; q.handle = '0; q.now = '0;
      end
      if (i == DEPTH - 1) begin
        q.dest = '1; q.port = '1; q.bid = '1; q.handle = '1; q.now = '1;
      end
      pending_reqs.push_back(q);
    end
    pending_reqs.push_back(make_req(FUNC_ADD, clock_s, dest_pool[0], 16'd77));
    pending_reqs.push_back(make_req(FUNC_DEL, clock_s, '0, 16'd5));
    pending_reqs.push_back(make_req(FUNC_DEL, clock_s, '0, 16'd999));
    q = make_req(FUNC_ROUTE, 32'd1, dest_pool[0], '0);  // first half stale, but for the entry stamped 0
    q.ifx = '1; q.nh = '1;
    pending_reqs.push_back(q);
    q = make_req(FUNC_ROUTE, 32'd2, '1, '0);
    q.ifx = '0; q.nh = '0;
    pending_reqs.push_back(q);
    pending_reqs.push_back(make_req(FUNC_ROUTE, 32'd100, dest_pool[1], '0));
    wait_idle();
    clock_s = 32'd1000;

    write_timeout(16'd1);
    random_phase(41);
    send_idle_pct = 48;
    recv_idle_pct = 31;
    write_timeout(16'd0);  // every entry stale
    random_phase(41);
    write_timeout(16'hFFFF);
    clock_s = 32'hFFFF_FF00;
    random_phase(41);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(16'($urandom_range(2, 20)));
    random_phase(41);
    write_timeout(16'd7);
    random_phase(41);

    $display("Run covered %0d requests and %0d result beats (%0d sends, %0d purges, %0d full)",
             reqs_taken, beats_seen, sends_seen, purges_seen, fulls_seen);
    $display("over timeouts 3, 1, 0, 65535, random and 7 s with three stall patterns");
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d beats still expected", mismatches,
               expected_beats.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
